[rtl/ale_pkg.sv]
// ----------------------------------------------------------------------------
// ale_pkg
// Shared constants, codes and types of the array list engine.
// ----------------------------------------------------------------------------
package ale_pkg;

  localparam int CAPACITY = 16;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int DATA_W   = 32;
  localparam int POS_W    = 8;

  // command codes
  typedef enum logic [3:0] {
    OP_PUSHBACK  = 4'd0,
    OP_PUSHFRONT = 4'd1,
    OP_INSERT    = 4'd2,
    OP_REMOVEAT  = 4'd3,
    OP_REMOVEVAL = 4'd4,
    OP_POPFRONT  = 4'd5,
    OP_POPBACK   = 4'd6,
    OP_CLEAR     = 4'd7,
    OP_INDEXOF   = 4'd8,
    OP_LASTINDEX = 4'd9,
    OP_REVERSE   = 4'd10,
    OP_SORTASC   = 4'd11,
    OP_SORTDESC  = 4'd12,
    OP_GET       = 4'd13,
    OP_SET       = 4'd14,
    OP_DUMP      = 4'd15
  } op_e;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BADINDEX = 2'd1,
    ST_FULL     = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_e;

  // access from the sequencer to the element store
  typedef struct packed {
    logic              we;
    logic [IDX_W-1:0]  waddr;
    logic [DATA_W-1:0] wdata;
    logic [IDX_W-1:0]  raddr;
  } store_req_t;

  // shared compare unit result
  typedef struct packed {
    logic eq;
    logic gt;
  } cmp_res_t;

endpackage

[rtl/ale_if.sv]
// ----------------------------------------------------------------------------
// ale_cmd_if / ale_res_if
// Valid/ready channels for commands and results.
// ----------------------------------------------------------------------------
interface ale_cmd_if;
  logic        valid;
  logic        ready;
  logic [3:0]  opcode;
  logic [7:0]  position_in;
  logic signed [31:0] value_in;

  modport source (output valid, opcode, position_in, value_in, input ready);
  modport sink   (input valid, opcode, position_in, value_in, output ready);
endinterface

interface ale_res_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic signed [31:0] value_out;
  logic [5:0]  found_position;
  logic [6:0]  count_after;
  logic        is_empty;
  logic        last;

  modport source (output valid, status, value_out, found_position, count_after,
                  is_empty, last, input ready);
  modport sink   (input valid, status, value_out, found_position, count_after,
                  is_empty, last, output ready);
endinterface

[rtl/array_list_engine_unit.sv]
// Sequence: clear and bad commands go straight to the result, get and set pass through one
// access step; shifts and searches walk the list one entry per cycle, reverse swaps the
// two ends a pair at a time; sort is insertion sort.
// Throughput: one command at a time; ready stays low until the sequencer is idle.
// Dump gives one result per cycle while the sink takes them.
// Reset: asynchronous, active low; clears the count and the result valid.
// ----------------------------------------------------------------------------
// array_list_engine_unit
// Bounded ordered list of signed words, driven by one command at a time.
// ----------------------------------------------------------------------------
module array_list_engine_unit (
  input  logic      clk_i,
  input  logic      rst_ni,
  ale_cmd_if.sink   cmd_i,
  ale_res_if.source res_o
);
  import ale_pkg::*;

  store_req_t        req;
  logic [DATA_W-1:0] rdata;
  logic [DATA_W-1:0] cmp_a;
  logic [DATA_W-1:0] cmp_b;
  cmp_res_t          cmp_res;

  ale_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (cmd_i),
    .res_o   (res_o),
    .req_o   (req),
    .rdata_i (rdata),
    .cmp_a_o (cmp_a),
    .cmp_b_o (cmp_b),
    .cmp_i   (cmp_res)
  );

  ale_store u_store (
    .clk_i   (clk_i),
    .req_i   (req),
    .rdata_o (rdata)
  );

  ale_cmp u_cmp (
    .a_i   (cmp_a),
    .b_i   (cmp_b),
    .res_o (cmp_res)
  );

endmodule

[rtl/ale_store.sv]
// ----------------------------------------------------------------------------
// ale_store
// Element register file: one write and one read address per cycle.
// ----------------------------------------------------------------------------
module ale_store (
  input  logic                        clk_i,
  input  ale_pkg::store_req_t         req_i,
  output logic [ale_pkg::DATA_W-1:0]  rdata_o
);
  import ale_pkg::*;

  logic [DATA_W-1:0] mem_q [CAPACITY];

  // write port
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
  end

  // read port
  assign rdata_o = mem_q[req_i.raddr];

endmodule

[rtl/ale_cmp.sv]
// ----------------------------------------------------------------------------
// ale_cmp
// Shared compare unit: equality and signed greater-than.
// ----------------------------------------------------------------------------
module ale_cmp (
  input  logic [ale_pkg::DATA_W-1:0] a_i,
  input  logic [ale_pkg::DATA_W-1:0] b_i,
  output ale_pkg::cmp_res_t          res_o
);
  import ale_pkg::*;

  assign res_o.eq = (a_i == b_i);
  assign res_o.gt = ($signed(a_i) > $signed(b_i));

endmodule

[rtl/ale_ctrl.sv]
// ----------------------------------------------------------------------------
// ale_ctrl
// Command sequencer: walks the store one entry at a time and drives results.
// ----------------------------------------------------------------------------
module ale_ctrl (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  ale_cmd_if.sink                     cmd_i,
  ale_res_if.source                   res_o,
  output ale_pkg::store_req_t         req_o,
  input  logic [ale_pkg::DATA_W-1:0]  rdata_i,
  output logic [ale_pkg::DATA_W-1:0]  cmp_a_o,
  output logic [ale_pkg::DATA_W-1:0]  cmp_b_o,
  input  ale_pkg::cmp_res_t           cmp_i
);
  import ale_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_INS, S_REM, S_RVAL, S_FIND, S_REV_A, S_REV_B, S_REV_C,
    S_SORT_KEY, S_SORT_CMP, S_RW, S_DUMP, S_DONE
  } state_e;

  state_e            state_q, state_d;
  op_e               op_q, op_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [CNT_W-1:0]  i_q, i_d;
  logic [CNT_W-1:0]  j_q, j_d;
  logic [CNT_W-1:0]  w_q, w_d;
  logic [CNT_W-1:0]  a_q, a_d;
  logic [DATA_W-1:0] val_q, val_d;
  logic [DATA_W-1:0] key_q, key_d;
  status_e           st_q, st_d;
  logic [DATA_W-1:0] rv_q, rv_d;
  logic [CNT_W-1:0]  fp_q, fp_d;

  logic              ov_q, ov_d;
  status_e           o_st_q, o_st_d;
  logic [DATA_W-1:0] o_val_q, o_val_d;
  logic [CNT_W-1:0]  o_fp_q, o_fp_d;
  logic [CNT_W-1:0]  o_cnt_q, o_cnt_d;
  logic              o_last_q, o_last_d;

  logic              out_free;
  logic              desc;
  logic [POS_W-1:0]  cnt_ext;
  logic [POS_W-1:0]  ins_pos;
  logic [IDX_W-1:0]  raddr;
  op_e               cmd_op;

  assign out_free     = !ov_q || res_o.ready;
  assign desc         = (op_q == OP_SORTDESC);
  assign cnt_ext      = POS_W'(cnt_q);
  assign cmd_op       = op_e'(cmd_i.opcode);
  assign cmd_i.ready  = (state_q == S_IDLE);

  // compare operands: sort order picks the direction, else search value
  always_comb begin
    if (state_q == S_SORT_CMP) begin
      cmp_a_o = desc ? key_q : rdata_i;
      cmp_b_o = desc ? rdata_i : key_q;
    end else begin
      cmp_a_o = rdata_i;
      cmp_b_o = val_q;
    end
  end

  // read address per step
  always_comb begin
    case (state_q)
      S_INS:      raddr = IDX_W'(i_q - CNT_W'(1));
      S_REM:      raddr = IDX_W'(i_q + CNT_W'(1));
      S_FIND:     raddr = (op_q == OP_LASTINDEX) ? IDX_W'(i_q - CNT_W'(1))
                                                 : IDX_W'(i_q);
      S_REV_B:    raddr = IDX_W'(j_q);
      S_SORT_CMP: raddr = IDX_W'(j_q - CNT_W'(1));
      S_RW:       raddr = IDX_W'(a_q);
      default:    raddr = IDX_W'(i_q);
    endcase
  end

  // sequencer next state
  always_comb begin
    state_d = state_q;  op_d = op_q;   cnt_d = cnt_q;  i_d = i_q;  j_d = j_q;
    w_d = w_q;  a_d = a_q;  val_d = val_q;  key_d = key_q;  st_d = st_q;
    rv_d = rv_q;  fp_d = fp_q;
    ov_d = ov_q && !res_o.ready;
    o_st_d = o_st_q;  o_val_d = o_val_q;  o_fp_d = o_fp_q;  o_cnt_d = o_cnt_q;
    o_last_d = o_last_q;
    req_o.we    = 1'b0;
    req_o.waddr = IDX_W'(i_q);
    req_o.wdata = rdata_i;
    req_o.raddr = raddr;
    ins_pos     = '0;

    case (state_q)
      S_IDLE: begin
        if (cmd_i.valid) begin
          op_d  = cmd_op;
          val_d = cmd_i.value_in;
          st_d  = ST_OK;
          rv_d  = '0;
          fp_d  = '0;
          state_d = S_DONE;
          case (cmd_op)
            OP_PUSHBACK, OP_PUSHFRONT, OP_INSERT: begin
              ins_pos = (cmd_op == OP_PUSHBACK)  ? cnt_ext :
                        (cmd_op == OP_PUSHFRONT) ? '0 : cmd_i.position_in;
              if (ins_pos > cnt_ext) begin
                st_d = ST_BADINDEX;
              end else if (cnt_q >= CNT_W'(CAPACITY)) begin
                st_d = ST_FULL;
              end else begin
                i_d = cnt_q;
                a_d = CNT_W'(ins_pos);
                state_d = S_INS;
              end
            end
            OP_REMOVEAT: begin
              if (cmd_i.position_in >= cnt_ext) begin
                st_d = ST_BADINDEX;
              end else begin
                i_d = CNT_W'(cmd_i.position_in);
                state_d = S_REM;
              end
            end
            OP_POPFRONT, OP_POPBACK: begin
              if (cnt_q == '0) begin
                st_d = ST_BADINDEX;
              end else begin
                i_d = (cmd_op == OP_POPBACK) ? cnt_q - CNT_W'(1) : '0;
                state_d = S_REM;
              end
            end
            OP_REMOVEVAL: begin
              i_d = '0;
              w_d = '0;
              state_d = S_RVAL;
            end
            OP_CLEAR: begin
              cnt_d = '0;
            end
            OP_INDEXOF, OP_LASTINDEX: begin
              i_d = (cmd_op == OP_LASTINDEX) ? cnt_q : '0;
              state_d = S_FIND;
            end
            OP_REVERSE: begin
              if (cnt_q != '0) begin
                i_d = '0;
                j_d = cnt_q - CNT_W'(1);
                state_d = S_REV_A;
              end
            end
            OP_SORTASC, OP_SORTDESC: begin
              i_d = CNT_W'(1);
              state_d = S_SORT_KEY;
            end
            OP_GET, OP_SET: begin
              if (cmd_i.position_in >= cnt_ext) begin
                st_d = ST_BADINDEX;
              end else begin
                a_d = CNT_W'(cmd_i.position_in);
                state_d = S_RW;
              end
            end
            default: begin
              if (cnt_q == '0) begin
                st_d = ST_BADINDEX;
              end else begin
                i_d = '0;
                state_d = S_DUMP;
              end
            end
          endcase
        end
      end

      // open a gap: move entries up from the back
      S_INS: begin
        req_o.we    = 1'b1;
        req_o.waddr = IDX_W'(i_q);
        if (i_q == a_q) begin
          req_o.wdata = val_q;
          cnt_d = cnt_q + CNT_W'(1);
          state_d = S_DONE;
        end else begin
          i_d = i_q - CNT_W'(1);
        end
      end

      // close a gap: move entries down
      S_REM: begin
        if (i_q + CNT_W'(1) >= cnt_q) begin
          cnt_d = cnt_q - CNT_W'(1);
          state_d = S_DONE;
        end else begin
          req_o.we    = 1'b1;
          req_o.waddr = IDX_W'(i_q);
          i_d = i_q + CNT_W'(1);
        end
      end

      // compact out every match
      S_RVAL: begin
        if (i_q == cnt_q) begin
          st_d  = (w_q == cnt_q) ? ST_NOTFOUND : ST_OK;
          cnt_d = w_q;
          state_d = S_DONE;
        end else begin
          if (!cmp_i.eq) begin
            req_o.we    = 1'b1;
            req_o.waddr = IDX_W'(w_q);
            w_d = w_q + CNT_W'(1);
          end
          i_d = i_q + CNT_W'(1);
        end
      end

      // linear search, forward or backward
      S_FIND: begin
        if (op_q == OP_LASTINDEX) begin
          if (i_q == '0) begin
            st_d = ST_NOTFOUND;
            state_d = S_DONE;
          end else if (cmp_i.eq) begin
            fp_d = i_q - CNT_W'(1);
            state_d = S_DONE;
          end else begin
            i_d = i_q - CNT_W'(1);
          end
        end else begin
          if (i_q == cnt_q) begin
            st_d = ST_NOTFOUND;
            state_d = S_DONE;
          end else if (cmp_i.eq) begin
            fp_d = i_q;
            state_d = S_DONE;
          end else begin
            i_d = i_q + CNT_W'(1);
          end
        end
      end

      // swap ends: hold low entry, copy high down, write held entry up
      S_REV_A: begin
        if (i_q >= j_q) begin
          state_d = S_DONE;
        end else begin
          key_d = rdata_i;
          state_d = S_REV_B;
        end
      end
      S_REV_B: begin
        req_o.we    = 1'b1;
        req_o.waddr = IDX_W'(i_q);
        state_d = S_REV_C;
      end
      S_REV_C: begin
        req_o.we    = 1'b1;
        req_o.waddr = IDX_W'(j_q);
        req_o.wdata = key_q;
        i_d = i_q + CNT_W'(1);
        j_d = j_q - CNT_W'(1);
        state_d = S_REV_A;
      end

      // insertion sort: pick key, then shift larger entries up (smaller ones for descending)
      S_SORT_KEY: begin
        if (i_q >= cnt_q) begin
          state_d = S_DONE;
        end else begin
          key_d = rdata_i;
          j_d = i_q;
          state_d = S_SORT_CMP;
        end
      end
      S_SORT_CMP: begin
        req_o.we    = 1'b1;
        req_o.waddr = IDX_W'(j_q);
        if (j_q != '0 && cmp_i.gt) begin
          j_d = j_q - CNT_W'(1);
        end else begin
          req_o.wdata = key_q;
          i_d = i_q + CNT_W'(1);
          state_d = S_SORT_KEY;
        end
      end

      // single read or write
      S_RW: begin
        if (op_q == OP_SET) begin
          req_o.we    = 1'b1;
          req_o.waddr = IDX_W'(a_q);
          req_o.wdata = val_q;
        end else begin
          rv_d = rdata_i;
        end
        state_d = S_DONE;
      end

      // stream every element
      S_DUMP: begin
        if (out_free) begin
          ov_d     = 1'b1;
          o_st_d   = ST_OK;
          o_val_d  = rdata_i;
          o_fp_d   = '0;
          o_cnt_d  = cnt_q;
          o_last_d = (i_q + CNT_W'(1) == cnt_q);
          i_d = i_q + CNT_W'(1);
          if (i_q + CNT_W'(1) == cnt_q) begin
            state_d = S_IDLE;
          end
        end
      end

      // single result transfer
      S_DONE: begin
        if (out_free) begin
          ov_d     = 1'b1;
          o_st_d   = st_q;
          o_val_d  = rv_q;
          o_fp_d   = fp_q;
          o_cnt_d  = cnt_q;
          o_last_d = 1'b1;
          state_d  = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    i_q      <= i_d;
    j_q      <= j_d;
    w_q      <= w_d;
    a_q      <= a_d;
    val_q    <= val_d;
    key_q    <= key_d;
    st_q     <= st_d;
    rv_q     <= rv_d;
    fp_q     <= fp_d;
    o_st_q   <= o_st_d;
    o_val_q  <= o_val_d;
    o_fp_q   <= o_fp_d;
    o_cnt_q  <= o_cnt_d;
    o_last_q <= o_last_d;
  end

  // result channel
  assign res_o.valid          = ov_q;
  assign res_o.status         = o_st_q;
  assign res_o.value_out      = o_val_q;
  assign res_o.found_position = 6'(o_fp_q);
  assign res_o.count_after    = 7'(o_cnt_q);
  assign res_o.is_empty       = (o_cnt_q == '0);
  assign res_o.last           = o_last_q;

endmodule
